// ===== sv/cna_pkg.sv =====
// Complex ALU package: operand/result transfer types, kind and status codes,
// pipeline widths and the CORDIC arctangent table. No dependencies.
`default_nettype none

package cna_pkg;

    localparam int DATA_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int KIND_W  = 4;
    localparam int STAT_W  = 2;
    localparam int SUM_W   = 2 * DATA_W + 1;
    localparam int MAG_W   = 2 * DATA_W;
    localparam int QUO_W   = DATA_W + 1;
    localparam int ROOT_W  = DATA_W;
    localparam int CORE_N  = 31;
    localparam int XY_W    = DATA_W + 4;
    localparam int ANG_W   = 34;
    localparam int ANG_RND = 30 - FRAC_W;

    localparam logic [KIND_W-1:0] KIND_ADD  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SUB  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MUL  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DIV  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_NEG  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_CONJ = 4'd5;
    localparam logic [KIND_W-1:0] KIND_MAG  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ARG  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_EQ   = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    // angles in units of 2^-30 rad
    localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;

    localparam logic [31:0] ATAN_TAB [CORE_N] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001
    };

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic [STAT_W-1:0]        status;
        logic                     is_equal;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic              neg_re;
        logic              neg_im;
        logic [MAG_W-1:0]  mag_re;
        logic [MAG_W-1:0]  mag_im;
        logic              den_zero;
        logic              eq;
    } side_t;

    typedef struct packed {
        side_t                    side;
        logic [MAG_W-1:0]         den;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
    } front_t;

endpackage

`default_nettype wire

// ===== sv/cna_front.sv =====
// Complex ALU front end: input register, products, sums and sign/magnitude split.
// Four register stages. Depends on cna_pkg.
`default_nettype none

module cna_front
    import cna_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   valid,
    input  req_t   req,
    output front_t front
);

    logic a_valid_reg;
    req_t a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= req;
        end
    end

    // products
    logic signed [DATA_W-1:0]   sq_re;
    logic signed [DATA_W-1:0]   sq_im;
    logic signed [2*DATA_W-1:0] p_next [6];
    logic                       eq_next;

    assign sq_re     = (a_reg.kind == KIND_MAG) ? a_reg.a_re : a_reg.b_re;
    assign sq_im     = (a_reg.kind == KIND_MAG) ? a_reg.a_im : a_reg.b_im;
    assign p_next[0] = a_reg.a_re * a_reg.b_re;
    assign p_next[1] = a_reg.a_im * a_reg.b_im;
    assign p_next[2] = a_reg.a_re * a_reg.b_im;
    assign p_next[3] = a_reg.a_im * a_reg.b_re;
    assign p_next[4] = sq_re * sq_re;
    assign p_next[5] = sq_im * sq_im;
    assign eq_next   = (a_reg.a_re == a_reg.b_re) && (a_reg.a_im == a_reg.b_im);

    logic                       b_valid_reg;
    req_t                       b_req_reg;
    logic signed [2*DATA_W-1:0] b_p_reg [6];
    logic                       b_eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_req_reg <= a_reg;
            b_p_reg   <= p_next;
            b_eq_reg  <= eq_next;
        end
    end

    // sums per kind
    logic signed [DATA_W-1:0] ar;
    logic signed [DATA_W-1:0] ai;
    logic signed [DATA_W-1:0] br;
    logic signed [DATA_W-1:0] bi;
    logic signed [SUM_W-1:0]  sr_next;
    logic signed [SUM_W-1:0]  si_next;
    logic [MAG_W-1:0]         den_next;

    assign ar = b_req_reg.a_re;
    assign ai = b_req_reg.a_im;
    assign br = b_req_reg.b_re;
    assign bi = b_req_reg.b_im;
    assign den_next = $unsigned(b_p_reg[4]) + $unsigned(b_p_reg[5]);

    always_comb
    begin
        sr_next = '0;
        si_next = '0;
        case (b_req_reg.kind)
            KIND_ADD:
            begin
                sr_next = SUM_W'(ar) + SUM_W'(br);
                si_next = SUM_W'(ai) + SUM_W'(bi);
            end
            KIND_SUB:
            begin
                sr_next = SUM_W'(ar) - SUM_W'(br);
                si_next = SUM_W'(ai) - SUM_W'(bi);
            end
            KIND_MUL:
            begin
                sr_next = SUM_W'(b_p_reg[0]) - SUM_W'(b_p_reg[1]);
                si_next = SUM_W'(b_p_reg[2]) + SUM_W'(b_p_reg[3]);
            end
            KIND_DIV:
            begin
                sr_next = SUM_W'(b_p_reg[0]) + SUM_W'(b_p_reg[1]);
                si_next = SUM_W'(b_p_reg[3]) - SUM_W'(b_p_reg[2]);
            end
            KIND_NEG:
            begin
                sr_next = SUM_W'(0) - SUM_W'(ar);
                si_next = SUM_W'(0) - SUM_W'(ai);
            end
            KIND_CONJ:
            begin
                sr_next = SUM_W'(ar);
                si_next = SUM_W'(0) - SUM_W'(ai);
            end
            KIND_MAG:
            begin
                sr_next = SUM_W'(b_p_reg[4]) + SUM_W'(b_p_reg[5]);
            end
            default:
            begin
                sr_next = '0;
                si_next = '0;
            end
        endcase
    end

    logic                     c_valid_reg;
    logic [KIND_W-1:0]        c_kind_reg;
    logic signed [SUM_W-1:0]  c_sr_reg;
    logic signed [SUM_W-1:0]  c_si_reg;
    logic [MAG_W-1:0]         c_den_reg;
    logic                     c_eq_reg;
    logic signed [DATA_W-1:0] c_a_re_reg;
    logic signed [DATA_W-1:0] c_a_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_kind_reg <= b_req_reg.kind;
            c_sr_reg   <= sr_next;
            c_si_reg   <= si_next;
            c_den_reg  <= den_next;
            c_eq_reg   <= b_eq_reg;
            c_a_re_reg <= ar;
            c_a_im_reg <= ai;
        end
    end

    // sign / magnitude split
    logic [SUM_W-1:0] nr;
    logic [SUM_W-1:0] ni;
    front_t           d_next;
    front_t           d_reg;

    assign nr = -c_sr_reg;
    assign ni = -c_si_reg;

    always_comb
    begin
        d_next.side.valid    = c_valid_reg;
        d_next.side.kind     = c_kind_reg;
        d_next.side.neg_re   = c_sr_reg[SUM_W-1];
        d_next.side.neg_im   = c_si_reg[SUM_W-1];
        d_next.side.mag_re   = c_sr_reg[SUM_W-1] ? nr[MAG_W-1:0] : c_sr_reg[MAG_W-1:0];
        d_next.side.mag_im   = c_si_reg[SUM_W-1] ? ni[MAG_W-1:0] : c_si_reg[MAG_W-1:0];
        d_next.side.den_zero = (c_den_reg == '0);
        d_next.side.eq       = c_eq_reg;
        d_next.den           = c_den_reg;
        d_next.a_re          = c_a_re_reg;
        d_next.a_im          = c_a_im_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign front = d_reg;

endmodule

`default_nettype wire

// ===== sv/cna_div.sv =====
// Complex ALU divider: restoring division, one quotient bit per register stage in the
// first QUO_W stages, floor(num * 2^FRAC_W / den) with overflow flag. Depends on cna_pkg.
`default_nettype none

module cna_div
    import cna_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] num,
    input  logic [MAG_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    localparam int REM_W = MAG_W + FRAC_W;
    localparam int CMP_W = MAG_W + QUO_W;
    localparam int OVF_W = MAG_W + QUO_W - FRAC_W;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] den;
        logic [QUO_W-1:0] q;
        logic             ovf;
    } div_t;

    div_t             st_in;
    div_t             st_reg [CORE_N];
    logic [OVF_W-1:0] nsh;

    // quotient needs more than QUO_W bits when num >= den * 2^(QUO_W - FRAC_W)
    assign nsh = {den, {(QUO_W - FRAC_W){1'b0}}};

    always_comb
    begin
        st_in.rem = {num, {FRAC_W{1'b0}}};
        st_in.den = den;
        st_in.q   = '0;
        st_in.ovf = (OVF_W'(num) >= nsh);
    end

    for (genvar i = 0; i < CORE_N; i++)
    begin : g_stage
        div_t cur;
        div_t st_next;

        if (i == 0)
        begin : g_first
            assign cur = st_in;
        end
        else
        begin : g_rest
            assign cur = st_reg[i-1];
        end

        if (i < QUO_W)
        begin : g_step
            localparam int K = QUO_W - 1 - i;
            logic [CMP_W-1:0] dsh;

            assign dsh = CMP_W'(cur.den) << K;

            always_comb
            begin
                st_next = cur;
                if (CMP_W'(cur.rem) >= dsh)
                begin
                    st_next.rem  = cur.rem - dsh[REM_W-1:0];
                    st_next.q[K] = 1'b1;
                end
            end
        end
        else
        begin : g_pass
            assign st_next = cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i] <= st_next;
            end
        end
    end

    assign quo = st_reg[CORE_N-1].q;
    assign ovf = st_reg[CORE_N-1].ovf;

endmodule

`default_nettype wire

// ===== sv/cna_sqrt.sv =====
// Complex ALU integer square root: one result bit per radicand bit pair in each of the
// first ROOT_W register stages. Depends on cna_pkg.
`default_nettype none

module cna_sqrt
    import cna_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MAG_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    typedef struct packed {
        logic [MAG_W-1:0] v;
        logic [MAG_W-1:0] r;
    } sq_t;

    sq_t st_in;
    sq_t st_reg [CORE_N];

    assign st_in.v = rad;
    assign st_in.r = '0;

    for (genvar i = 0; i < CORE_N; i++)
    begin : g_stage
        sq_t cur;
        sq_t st_next;

        if (i == 0)
        begin : g_first
            assign cur = st_in;
        end
        else
        begin : g_rest
            assign cur = st_reg[i-1];
        end

        if (i < ROOT_W)
        begin : g_step
            localparam logic [MAG_W-1:0] BIT = MAG_W'(1) << (MAG_W - 2 - 2 * i);
            logic [MAG_W-1:0] t;

            assign t = cur.r + BIT;

            always_comb
            begin
                if (cur.v >= t)
                begin
                    st_next.v = cur.v - t;
                    st_next.r = (cur.r >> 1) + BIT;
                end
                else
                begin
                    st_next.v = cur.v;
                    st_next.r = cur.r >> 1;
                end
            end
        end
        else
        begin : g_pass
            assign st_next = cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i] <= st_next;
            end
        end
    end

    assign root = st_reg[CORE_N-1].r[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/cna_cordic.sv =====
// Complex ALU arctangent: vectoring CORDIC, one iteration per register stage,
// axis cases and left half-plane pre-rotation at entry. Depends on cna_pkg.
`default_nettype none

module cna_cordic
    import cna_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [DATA_W-1:0] a_re,
    input  logic signed [DATA_W-1:0] a_im,
    output logic signed [ANG_W-1:0]  ang
);

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    skip;
    } cor_t;

    cor_t st_in;
    cor_t st_reg [CORE_N];

    always_comb
    begin
        st_in.x    = XY_W'(a_re);
        st_in.y    = XY_W'(a_im);
        st_in.z    = '0;
        st_in.skip = 1'b0;
        if (a_re == '0)
        begin
            st_in.skip = 1'b1;
            if (a_im > 0)
            begin
                st_in.z = ANG_HALF_PI;
            end
            else if (a_im < 0)
            begin
                st_in.z = -ANG_HALF_PI;
            end
        end
        else if (a_im == '0)
        begin
            st_in.skip = 1'b1;
            if (a_re < 0)
            begin
                st_in.z = ANG_PI;
            end
        end
        else if (a_re < 0)
        begin
            st_in.x = -XY_W'(a_re);
            st_in.y = -XY_W'(a_im);
            st_in.z = (a_im >= 0) ? ANG_PI : -ANG_PI;
        end
    end

    for (genvar i = 0; i < CORE_N; i++)
    begin : g_stage
        localparam logic signed [ANG_W-1:0] AT = ANG_W'(ATAN_TAB[i]);
        cor_t cur;
        cor_t st_next;

        if (i == 0)
        begin : g_first
            assign cur = st_in;
        end
        else
        begin : g_rest
            assign cur = st_reg[i-1];
        end

        always_comb
        begin
            st_next = cur;
            if (!cur.skip)
            begin
                if (cur.y > 0)
                begin
                    st_next.x = cur.x + (cur.y >>> i);
                    st_next.y = cur.y - (cur.x >>> i);
                    st_next.z = cur.z + AT;
                end
                else
                begin
                    st_next.x = cur.x - (cur.y >>> i);
                    st_next.y = cur.y + (cur.x >>> i);
                    st_next.z = cur.z - AT;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i] <= st_next;
            end
        end
    end

    assign ang = st_reg[CORE_N-1].z;

endmodule

`default_nettype wire

// ===== sv/complex_number_alu.sv =====
// Complex ALU top level: front end, divider, square root and CORDIC pipelines,
// final rounding/saturation and output register. Depends on cna_pkg and submodules.
// One transfer per cycle is taken while the output is not stalled; a stall raises req_stall.
// The 31-stage CORDIC sets the depth; divider and root pad to the same length.
// A stalled result holds the whole pipeline. Reset clears all valid bits.
`default_nettype none

module complex_number_alu
    import cna_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic signed [ANG_W-1:0] ANG_HALF_LSB = ANG_W'(1) << (ANG_RND - 1);

    logic                     en;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    front_t                   front;
    side_t                    side_reg [CORE_N];
    side_t                    fin;
    logic [QUO_W-1:0]         q_re;
    logic [QUO_W-1:0]         q_im;
    logic                     ovf_re;
    logic                     ovf_im;
    logic [ROOT_W-1:0]        root;
    logic signed [ANG_W-1:0]  ang;

    assign en        = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !en;

    cna_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .valid (req_valid),
        .req   (req),
        .front (front)
    );

    cna_div u_div_re (
        .clk (clk),
        .en  (en),
        .num (front.side.mag_re),
        .den (front.den),
        .quo (q_re),
        .ovf (ovf_re)
    );

    cna_div u_div_im (
        .clk (clk),
        .en  (en),
        .num (front.side.mag_im),
        .den (front.den),
        .quo (q_im),
        .ovf (ovf_im)
    );

    cna_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (front.side.mag_re),
        .root (root)
    );

    cna_cordic u_cordic (
        .clk  (clk),
        .en   (en),
        .a_re (front.a_re),
        .a_im (front.a_im),
        .ang  (ang)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORE_N; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0] <= front.side;
            for (int i = 1; i < CORE_N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign fin = side_reg[CORE_N-1];

    // {saturated, value}
    function automatic logic [DATA_W:0] sat_fn(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0]  lim;
        logic [MAG_W-1:0]  nm;
        logic [DATA_W-1:0] val;
        logic              flag;
        lim = MAG_W'(1) << (DATA_W - 1);
        if (!neg)
        begin
            lim = lim - MAG_W'(1);
        end
        nm = -mag;
        if (mag > lim)
        begin
            flag = 1'b1;
            val  = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            flag = 1'b0;
            val  = neg ? nm[DATA_W-1:0] : mag[DATA_W-1:0];
        end
        return {flag, val};
    endfunction

    logic [DATA_W:0]         sr;
    logic [DATA_W:0]         si;
    logic                    div0;
    logic                    eq;
    logic signed [ANG_W-1:0] zt;
    logic signed [ANG_W-1:0] zr;
    logic [ANG_W-1:0]        zabs;

    assign zt   = ang + ANG_HALF_LSB;
    assign zr   = zt >>> ANG_RND;
    assign zabs = zr[ANG_W-1] ? -zr : zr;

    always_comb
    begin
        sr   = '0;
        si   = '0;
        div0 = 1'b0;
        eq   = 1'b0;
        case (fin.kind)
            KIND_ADD, KIND_SUB, KIND_NEG, KIND_CONJ:
            begin
                sr = sat_fn(fin.neg_re, fin.mag_re);
                si = sat_fn(fin.neg_im, fin.mag_im);
            end
            KIND_MUL:
            begin
                sr = sat_fn(fin.neg_re, fin.mag_re >> FRAC_W);
                si = sat_fn(fin.neg_im, fin.mag_im >> FRAC_W);
            end
            KIND_DIV:
            begin
                if (fin.den_zero)
                begin
                    div0 = 1'b1;
                end
                else
                begin
                    sr = sat_fn(fin.neg_re, ovf_re ? '1 : MAG_W'(q_re));
                    si = sat_fn(fin.neg_im, ovf_im ? '1 : MAG_W'(q_im));
                end
            end
            KIND_MAG:
            begin
                sr = sat_fn(1'b0, MAG_W'(root));
            end
            KIND_ARG:
            begin
                sr = sat_fn(zr[ANG_W-1], zabs[MAG_W-1:0]);
            end
            KIND_EQ:
            begin
                eq = fin.eq;
            end
            default:
            begin
                sr = '0;
            end
        endcase

        rsp_next.res_re   = sr[DATA_W-1:0];
        rsp_next.res_im   = si[DATA_W-1:0];
        rsp_next.is_equal = eq;
        if (sr[DATA_W] || si[DATA_W])
        begin
            rsp_next.status = ST_SAT;
        end
        else if (div0)
        begin
            rsp_next.status = ST_DIV0;
        end
        else
        begin
            rsp_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_DIV0 |-> rsp.res_re == '0 && rsp.res_im == '0)
        else $error("div by zero result not cleared");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_equal |-> rsp.status == ST_OK && rsp.res_re == '0
                                      && rsp.res_im == '0)
        else $error("equal transfer carries data");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        en && fin.valid |=> rsp_valid)
        else $error("result lost at output register");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(fin) && $stable(front))
        else $error("pipeline moved under stall");
`endif

endmodule

`default_nettype wire
